// File: hdl/u2dec_pkg.sv
// ============================================================================
// u2dec_pkg: shared types and constants for the decimal ASCII converter
// Digit record layout, field widths and the divide-by-ten reciprocal.
// ============================================================================
package u2dec_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int VAL_W      = 32;
    localparam int DIG_W      = 4;
    localparam int ASCII_W    = 6;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int PROD_W     = 2 * VAL_W;
    localparam int RECIP_SH   = 35;

    localparam logic [VAL_W-1:0]   RECIP_TEN  = 32'hCCCC_CCCD;
    localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [DIG_W-1:0] t_digit;

    typedef struct packed {
        logic [MAX_DIGITS-1:0][DIG_W-1:0] digits;
        logic [CNT_W-1:0]                 count;
    } t_rec;

endpackage

// File: hdl/unsigned_to_decimal_ascii_top.sv
// ============================================================================
// unsigned_to_decimal_ascii_top: 32-bit unsigned to decimal ASCII converter
// Emits the decimal digits of each value, most significant first.
// ============================================================================
// Input channel: drive i_value and i_push; the value transfers on a rising
// edge with i_push high and o_full low. Output channel: while o_empty is low
// o_ascii_digit holds the oldest character and o_last_digit marks the least
// significant digit of a run; it transfers on an edge with i_pop high.
// Leading zeros are dropped; zero gives the single character '0'. Values
// with more than MAX_DIGITS digits keep only their low MAX_DIGITS digits.
// Throughput: the extractor divides by ten once per cycle, so a value with
// d digits takes d divide steps (1 to 10), and the next value is accepted
// as its record enters the queue. The emitter sends one character per
// cycle while the receiver pops each one. A two-entry record queue sits
// between extractor and emitter. When the receiver stalls, the output
// register holds, the queue fills, and o_full stays high until the queue
// takes the record. Reset clears all control state and drops pending output.
// ============================================================================
module unsigned_to_decimal_ascii_top
    import u2dec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [VAL_W-1:0]   i_value,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [ASCII_W-1:0] o_ascii_digit,
    output logic               o_last_digit
);

    logic fq_wr;
    t_rec fq_wr_rec;
    logic fq_full;
    logic fq_rd;
    t_rec fq_rd_rec;
    logic fq_empty;

    u2dec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_value     (i_value),
        .o_wr        (fq_wr),
        .o_rec       (fq_wr_rec),
        .i_fifo_full (fq_full)
    );

    u2dec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fq_wr),
        .i_rec   (fq_wr_rec),
        .o_full  (fq_full),
        .i_rd    (fq_rd),
        .o_rec   (fq_rd_rec),
        .o_empty (fq_empty)
    );

    u2dec_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec         (fq_rd_rec),
        .i_fifo_empty  (fq_empty),
        .o_fifo_rd     (fq_rd),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_ascii_digit (o_ascii_digit),
        .o_last_digit  (o_last_digit)
    );

endmodule

// File: hdl/u2dec_front.sv
// ============================================================================
// u2dec_front: value intake and digit extraction
// Takes one value, peels one decimal digit per cycle and hands the record on.
// ============================================================================
module u2dec_front
    import u2dec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_wr,
    output t_rec             o_rec,
    input  logic             i_fifo_full
);

    logic                             r_busy;
    logic [VAL_W-1:0]                 r_val;
    logic [IDX_W-1:0]                 r_cnt;
    logic [CNT_W-1:0]                 r_nz;
    logic [MAX_DIGITS-1:0][DIG_W-1:0] r_digits;

    logic [MAX_DIGITS-1:0][DIG_W-1:0] n_digits;
    logic [CNT_W-1:0]                 n_nz;
    logic [PROD_W-1:0]                prod;
    logic [VAL_W-1:0]                 quot;
    logic [VAL_W-1:0]                 tenq;
    logic [VAL_W-1:0]                 rem;
    t_digit                           dig;
    logic                             done;
    logic                             fin;
    logic                             accept;

    always_comb begin
        prod     = PROD_W'(r_val) * PROD_W'(RECIP_TEN);
        quot     = VAL_W'(prod >> RECIP_SH);
        tenq     = (quot << 3) + (quot << 1);
        rem      = r_val - tenq;
        dig      = rem[DIG_W-1:0];
        n_digits = r_digits;
        n_digits[r_cnt] = dig;
        n_nz     = (dig != '0) ? (CNT_W'(r_cnt) + 1'b1) : r_nz;
        done     = r_busy && ((quot == '0) || (r_cnt == IDX_W'(MAX_DIGITS - 1)));
        fin      = done && !i_fifo_full;
        o_full   = r_busy && !fin;
        accept   = i_push && !o_full;
        o_wr     = fin;
        o_rec.digits = n_digits;
        o_rec.count  = (n_nz == '0) ? CNT_W'(1) : n_nz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (fin) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val <= i_value;
            r_cnt <= '0;
            r_nz  <= '0;
        end else if (r_busy && !done) begin
            r_val    <= quot;
            r_cnt    <= r_cnt + 1'b1;
            r_nz     <= n_nz;
            r_digits <= n_digits;
        end
    end

endmodule

// File: hdl/u2dec_fifo.sv
// ============================================================================
// u2dec_fifo: two-entry record queue
// Decouples digit extraction from character output.
// ============================================================================
module u2dec_fifo
    import u2dec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_rd,
    output t_rec o_rec,
    output logic o_empty
);

    t_rec       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic wr_en;
    logic rd_en;

    always_comb begin
        o_full  = (r_cnt == 2'd2);
        o_empty = (r_cnt == 2'd0);
        wr_en   = i_wr && !o_full;
        rd_en   = i_rd && !o_empty;
        o_rec   = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_rec;
        end
    end

endmodule

// File: hdl/u2dec_back.sv
// ============================================================================
// u2dec_back: character emitter
// Walks a digit record from the top digit down into the output register.
// ============================================================================
module u2dec_back
    import u2dec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_rec               i_rec,
    input  logic               i_fifo_empty,
    output logic               o_fifo_rd,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [ASCII_W-1:0] o_ascii_digit,
    output logic               o_last_digit
);

    logic               r_act;
    t_rec               r_rec;
    logic [IDX_W-1:0]   r_pos;
    logic               r_ov;
    logic [ASCII_W-1:0] r_od;
    logic               r_ol;

    logic   out_ld;
    logic   step;
    logic   at_end;
    t_digit cur;

    always_comb begin
        out_ld    = !r_ov || i_pop;
        step      = r_act && out_ld;
        at_end    = (r_pos == '0);
        cur       = r_rec.digits[r_pos];
        o_fifo_rd = !i_fifo_empty && (!r_act || (step && at_end));
        o_empty   = !r_ov;
        o_ascii_digit = r_od;
        o_last_digit  = r_ol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (o_fifo_rd) begin
                r_act <= 1'b1;
            end else if (step && at_end) begin
                r_act <= 1'b0;
            end
            if (step) begin
                r_ov <= 1'b1;
            end else if (out_ld) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fifo_rd) begin
            r_rec <= i_rec;
            r_pos <= IDX_W'(i_rec.count - 1'b1);
        end else if (step && !at_end) begin
            r_pos <= r_pos - 1'b1;
        end
        if (step) begin
            r_od <= ASCII_ZERO + ASCII_W'(cur);
            r_ol <= at_end;
        end
    end

endmodule
